>>> src/wmsed_pkg.sv
package wmsed_pkg;

   localparam int SAMPLE_W   = 20;
   localparam int TH_W       = 24;
   localparam int CL_W       = 8;
   localparam int WINDOW     = 20;
   localparam int RING_DEPTH = 2 * WINDOW;
   localparam int POS_W      = $clog2(RING_DEPTH);
   localparam int WIN_W      = $clog2(WINDOW + 1);
   localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
   localparam int DIFF_W     = SUM_W + 1;
   localparam int LIM_W      = TH_W + WIN_W;
   localparam int CMP_W      = (DIFF_W > LIM_W) ? DIFF_W : LIM_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_W      = TH_W;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD      = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CAPTURE_LENGTH = CSR_IDX_W'(1);

   localparam logic [TH_W-1:0] THRESHOLD_RESET      = TH_W'(640);
   localparam logic [CL_W-1:0] CAPTURE_LENGTH_RESET = CL_W'(100);

   localparam logic [POS_W-1:0] WINDOW_POS   = POS_W'(WINDOW);
   localparam logic [POS_W-1:0] WIN_LAST_POS = POS_W'(WINDOW - 1);
   localparam logic [POS_W-1:0] LAST_POS     = POS_W'(RING_DEPTH - 1);

   typedef struct packed {
      logic                       check_made;
      logic                       event_detected;
      logic                       capture_valid;
      logic [CL_W-1:0]            capture_index;
      logic signed [SAMPLE_W-1:0] capture_sample;
      logic                       capture_end;
   } result_type;

   function automatic logic [POS_W-1:0] opposite(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] opp;
      if (pos < WINDOW_POS) begin
         opp = pos + WINDOW_POS;
      end else begin
         opp = pos - WINDOW_POS;
      end
      return opp;
   endfunction

endpackage

>>> src/wmsed_req_if.sv
interface wmsed_req_if;
   import wmsed_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source(output valid, output sample, input ready);
   modport sink(input valid, input sample, output ready);
endinterface

>>> src/wmsed_rsp_if.sv
interface wmsed_rsp_if;
   import wmsed_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       check_made;
   logic                       event_detected;
   logic                       capture_valid;
   logic [CL_W-1:0]            capture_index;
   logic signed [SAMPLE_W-1:0] capture_sample;
   logic                       capture_end;

   modport source(output valid, output check_made, output event_detected,
                  output capture_valid, output capture_index, output capture_sample,
                  output capture_end, input ready);
   modport sink(input valid, input check_made, input event_detected,
                input capture_valid, input capture_index, input capture_sample,
                input capture_end, output ready);
endinterface

>>> src/wmsed_ram.sv
module wmsed_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/wmsed_core.sv
module wmsed_core (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  logic signed [wmsed_pkg::SAMPLE_W-1:0]       sample,
   input  logic [wmsed_pkg::TH_W-1:0]                  threshold,
   input  logic [wmsed_pkg::CL_W-1:0]                  capture_length,
   output wmsed_pkg::result_type                       result
);
   import wmsed_pkg::*;

   logic [POS_W-1:0]           pos_ff, pos_in;
   logic                       filled_ff, filled_in;
   logic                       capturing_ff, capturing_in;
   logic [CL_W-1:0]            count_ff, count_in;
   logic signed [SUM_W-1:0]    cur_sum_ff, cur_sum_in;
   logic signed [SUM_W-1:0]    prev_sum_ff, prev_sum_in;

   logic [SAMPLE_W-1:0]        rd_data;
   logic [POS_W-1:0]           rd_addr;
   logic                       wr_en;
   logic signed [SAMPLE_W-1:0] leaving;
   logic signed [SUM_W-1:0]    cur_upd;
   logic signed [SUM_W-1:0]    prev_fill;
   logic signed [DIFF_W-1:0]   diff;
   logic [DIFF_W-1:0]          mag;
   logic [LIM_W-1:0]           limit;
   logic                       filled_now;
   logic                       check;
   logic                       exceed;
   logic [POS_W-1:0]           pos_next;

   // The ring entry leaving the current window is read ahead of its use, since the ring read is registered.
   assign rd_addr = opposite(advance ? pos_in : pos_ff);

   wmsed_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(pos_ff),
      .wr_data(sample),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // While the ring fills, entries not yet written since the restart read as zero.
   assign leaving    = (filled_ff || pos_ff >= WINDOW_POS) ? $signed(rd_data) : '0;
   assign cur_upd    = cur_sum_ff + SUM_W'(sample) - SUM_W'(leaving);
   assign prev_fill  = filled_ff ? prev_sum_ff : prev_sum_ff + SUM_W'(leaving);
   assign filled_now = filled_ff || (pos_ff == LAST_POS);
   assign check      = filled_now && (pos_ff == WIN_LAST_POS || pos_ff == LAST_POS);
   assign diff       = DIFF_W'(prev_fill) - DIFF_W'(cur_upd);
   assign mag        = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign limit      = LIM_W'(threshold) * LIM_W'(WINDOW);
   assign exceed     = CMP_W'(mag) > CMP_W'(limit);
   assign pos_next   = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);

   always_comb begin
      pos_in       = pos_ff;
      filled_in    = filled_ff;
      capturing_in = capturing_ff;
      count_in     = count_ff;
      cur_sum_in   = cur_sum_ff;
      prev_sum_in  = prev_sum_ff;
      wr_en        = 1'b0;
      result       = '0;
      if (!capturing_ff) begin
         wr_en             = advance;
         pos_in            = pos_next;
         filled_in         = filled_now;
         cur_sum_in        = cur_upd;
         prev_sum_in       = check ? cur_upd : prev_fill;
         result.check_made = check;
         if (check && exceed) begin
            result.event_detected = 1'b1;
            capturing_in          = 1'b1;
            count_in              = '0;
         end
      end else if (count_ff < capture_length) begin
         result.capture_valid  = 1'b1;
         result.capture_index  = count_ff;
         result.capture_sample = sample;
         count_in              = count_ff + CL_W'(1);
      end else begin
         result.capture_end = 1'b1;
         pos_in             = '0;
         filled_in          = 1'b0;
         capturing_in       = 1'b0;
         count_in           = '0;
         cur_sum_in         = '0;
         prev_sum_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         filled_ff    <= 1'b0;
         capturing_ff <= 1'b0;
         count_ff     <= '0;
         cur_sum_ff   <= '0;
         prev_sum_ff  <= '0;
      end else if (advance) begin
         pos_ff       <= pos_in;
         filled_ff    <= filled_in;
         capturing_ff <= capturing_in;
         count_ff     <= count_in;
         cur_sum_ff   <= cur_sum_in;
         prev_sum_ff  <= prev_sum_in;
      end
   end

   a_event_starts_capture: assert property (@(posedge clock) disable iff (reset)
      advance && result.event_detected |=> capturing_ff && count_ff == '0)
      else $error("event did not start a capture");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      advance && result.capture_end |=> !capturing_ff && !filled_ff && pos_ff == '0
         && cur_sum_ff == '0 && prev_sum_ff == '0)
      else $error("capture end did not restart detection");

   a_capture_freezes_sums: assert property (@(posedge clock) disable iff (reset)
      advance && capturing_ff && !result.capture_end |=>
         $stable(cur_sum_ff) && $stable(prev_sum_ff) && $stable(pos_ff))
      else $error("window state changed during a capture");

   a_ring_fills: assert property (@(posedge clock) disable iff (reset)
      advance && !capturing_ff && pos_ff == LAST_POS |=> filled_ff && pos_ff == '0)
      else $error("ring did not mark itself full at wrap");

endmodule

>>> src/window_mean_step_event_detector_top.sv
// Each sample passes the input register, then its result is registered and offered on rsp_ch.
// Throughput: one item per cycle unless a result waits; an empty input register still takes one.
// While detecting, the work per item is one registered ring read, one ring write and the window sum adds.
// Reset clears the window state and restores the threshold and capture length defaults.
// The history ring is not cleared; entries not yet written since a restart read as zero.
module window_mean_step_event_detector_top (
   input  logic                              clock,
   input  logic                              reset,
   wmsed_req_if.sink                         req_ch,
   wmsed_rsp_if.source                       rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [wmsed_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [wmsed_pkg::CSR_W-1:0]       csr_wr_data
);
   import wmsed_pkg::*;

   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   result_type                 rsp_data_ff;
   result_type                 result;
   logic [TH_W-1:0]            threshold_ff;
   logic [CL_W-1:0]            capture_length_ff;
   logic                       req_xfer;
   logic                       advance;

   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);

   wmsed_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .sample        (in_sample_ff),
      .threshold     (threshold_ff),
      .capture_length(capture_length_ff),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         threshold_ff      <= THRESHOLD_RESET;
         capture_length_ff <= CAPTURE_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_THRESHOLD: begin
                  threshold_ff <= csr_wr_data[TH_W-1:0];
               end
               CSR_CAPTURE_LENGTH: begin
                  capture_length_ff <= csr_wr_data[CL_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sample_ff <= req_ch.sample;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.check_made     = rsp_data_ff.check_made;
   assign rsp_ch.event_detected = rsp_data_ff.event_detected;
   assign rsp_ch.capture_valid  = rsp_data_ff.capture_valid;
   assign rsp_ch.capture_index  = rsp_data_ff.capture_index;
   assign rsp_ch.capture_sample = rsp_data_ff.capture_sample;
   assign rsp_ch.capture_end    = rsp_data_ff.capture_end;

endmodule

>>> verif/step_event_result_check.sv
module step_event_result_check (
   input  logic                            clock,
   input  logic                            reset,
   wmsed_req_if                            req_ch,
   wmsed_rsp_if                            rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [wmsed_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wmsed_pkg::CSR_W-1:0]     csr_wr_data,
   output int                              mismatch_count,
   output int                              results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import wmsed_pkg::*;

   logic signed [SAMPLE_W-1:0] window_ring [RING_DEPTH];
   longint                     newer_sum;
   longint                     older_sum;
   int                         ring_slot;
   bit                         ring_full;
   bit                         in_capture;
   int                         captured_count;
   logic [TH_W-1:0]            threshold_val;
   logic [CL_W-1:0]            capture_len;
   result_type                 step_results_due [$];

   function automatic void clear_windows();
      foreach (window_ring[i]) begin
         window_ring[i] = '0;
      end
      newer_sum      = 0;
      older_sum      = 0;
      ring_slot      = 0;
      ring_full      = 1'b0;
      in_capture     = 1'b0;
      captured_count = 0;
   endfunction

   function automatic result_type next_step_result(input logic signed [SAMPLE_W-1:0] s);
      result_type                 r;
      int                         opp;
      logic signed [SAMPLE_W-1:0] leaving;
      longint                     diff;
      r = '0;
      if (!in_capture) begin
         opp = (ring_slot < WINDOW) ? ring_slot + WINDOW : ring_slot - WINDOW;
         leaving = window_ring[opp];
         newer_sum += longint'(s) - longint'(leaving);
         if (!ring_full) begin
            older_sum += longint'(leaving) - longint'(window_ring[ring_slot]);
         end
         window_ring[ring_slot] = s;
         if (ring_slot == RING_DEPTH - 1) begin
            ring_full = 1'b1;
         end
         if (ring_full && ((ring_slot + 1) % WINDOW) == 0) begin
            r.check_made = 1'b1;
            diff = older_sum - newer_sum;
            if (diff < 0) begin
               diff = -diff;
            end
            if (diff > longint'(threshold_val) * WINDOW) begin
               r.event_detected = 1'b1;
               in_capture       = 1'b1;
               captured_count   = 0;
            end
            older_sum = newer_sum;
         end
         ring_slot = (ring_slot + 1) % RING_DEPTH;
      end else if (captured_count < capture_len) begin
         r.capture_valid  = 1'b1;
         r.capture_index  = CL_W'(captured_count);
         r.capture_sample = s;
         captured_count++;
      end else begin
         r.capture_end = 1'b1;
         clear_windows();
      end
      return r;
   endfunction

   task automatic check_field(input string field, input logic signed [31:0] want,
                              input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         threshold_val = THRESHOLD_RESET;
         capture_len   = CAPTURE_LENGTH_RESET;
         clear_windows();
         step_results_due.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_THRESHOLD) begin
               threshold_val = csr_wr_data[TH_W-1:0];
            end else if (csr_index == CSR_CAPTURE_LENGTH) begin
               capture_len = csr_wr_data[CL_W-1:0];
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (step_results_due.size() == 0) begin
               $error("result transfer with no sample waiting for it");
               mismatch_count++;
            end else begin
               want = step_results_due.pop_front();
               check_field("check_made", want.check_made, rsp_ch.check_made);
               check_field("event_detected", want.event_detected, rsp_ch.event_detected);
               check_field("capture_valid", want.capture_valid, rsp_ch.capture_valid);
               check_field("capture_index", want.capture_index, rsp_ch.capture_index);
               check_field("capture_sample", want.capture_sample, rsp_ch.capture_sample);
               check_field("capture_end", want.capture_end, rsp_ch.capture_end);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            step_results_due.push_back(next_step_result(req_ch.sample));
         end
      end
      results_pending = step_results_due.size();
   end

endmodule

>>> verif/tb_window_mean_step_event_detector_top.sv
module tb_window_mean_step_event_detector_top;
   timeunit 1ns;
   timeprecision 1ps;
   import wmsed_pkg::*;

   localparam int ITEM_TARGET   = 1450;
   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int SAMPLE_MAX    = 2 ** (SAMPLE_W - 1) - 1;
   localparam int SAMPLE_MIN    = -(2 ** (SAMPLE_W - 1));
   localparam int LEVEL_LIMIT   = 400000;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wr_data;
   int                   hold_requests = 0;
   int                   mismatch_count;
   int                   results_pending;
   int                   items_sent  = 0;
   int                   burst_left  = 0;
   int                   level_now   = 0;
   int                   events_seen = 0;

   logic signed [SAMPLE_W-1:0] extremes [8] = '{20'sh7FFFF, 20'sh80000, 20'sh00000, -20'sd1,
                                               20'sd1, 20'sh55555, 20'shAAAAA, 20'sh7FFFF};

   wmsed_req_if req_ch();
   wmsed_rsp_if rsp_ch();

   window_mean_step_event_detector_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   step_event_result_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready && rsp_ch.event_detected) begin
         events_seen++;
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("tb_window_mean_step_event_detector_top failed");
      $finish;
   end

   initial begin : receiver
      int seg_left;
      int style;
      int period;
      int tick;
      int holds_done;
      seg_left   = 0;
      style      = 0;
      period     = 1;
      tick       = 0;
      holds_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(20, 200);
               style    = $urandom_range(3);
               period   = $urandom_range(2, 5);
            end
            seg_left--;
            tick++;
            case (style)
               0: begin
                  rsp_ch.ready <= 1'b1;
               end
               1: begin
                  rsp_ch.ready <= 1'($urandom_range(1));
               end
               2: begin
                  rsp_ch.ready <= (tick % period) == 0;
               end
               default: begin
                  rsp_ch.ready <= $urandom_range(7) != 0;
               end
            endcase
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] clip_sample(input int v);
      if (v > SAMPLE_MAX) begin
         v = SAMPLE_MAX;
      end else if (v < SAMPLE_MIN) begin
         v = SAMPLE_MIN;
      end
      return SAMPLE_W'(v);
   endfunction

   function automatic int spread(input int amount);
      return int'($urandom_range(2 * amount)) - amount;
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid  <= 1'b1;
      req_ch.sample <= s;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_sample(SAMPLE_W'($urandom));
   endtask

   task automatic send_windows(input int windows, input int noise, input int step_pct,
                               input int step_max);
      repeat (windows) begin
         if ($urandom_range(99) < step_pct) begin
            level_now += spread(step_max);
            if (level_now > LEVEL_LIMIT) begin
               level_now = LEVEL_LIMIT;
            end else if (level_now < -LEVEL_LIMIT) begin
               level_now = -LEVEL_LIMIT;
            end
         end
         repeat (WINDOW) send_sample(clip_sample(level_now + spread(noise)));
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (results_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [TH_W-1:0] th, input int cl);
      write_reg(CSR_THRESHOLD, CSR_W'(th));
      write_reg(CSR_CAPTURE_LENGTH, CSR_W'(cl));
   endtask

   initial begin : stimulus
      int              e0;
      int              tries;
      int              cl;
      logic [TH_W-1:0] th;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.sample = '0;
      csr_wr_en     = 1'b0;
      csr_index     = CSR_THRESHOLD;
      csr_wr_data   = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults, field extremes, then level steps around the default threshold.
      foreach (extremes[i]) begin
         send_sample(extremes[i]);
      end
      level_now = 0;
      send_windows(12, 200, 50, 20000);
      drain();

      // A zero capture length ends the capture on the sample right after the event.
      set_config('0, 0);
      level_now = 1000;
      send_windows(3, 0, 0, 0);
      send_windows(4, 0, 100, 50000);
      drain();

      // Lower the capture length below the count already reached mid-capture.
      set_config('0, 200);
      e0    = events_seen;
      tries = 0;
      while (events_seen == e0 && tries < 20) begin
         send_windows(1, 50, 100, 30000);
         drain();
         tries++;
      end
      send_noise(10);
      drain();
      set_config('0, 3);
      send_windows(3, 50, 100, 30000);
      drain();

      set_config(TH_W'(800), 255);
      send_windows(20, 100, 60, 60000);
      drain();

      set_config({TH_W{1'b1}}, 1);
      send_noise(120);
      drain();

      // The receiver holds off long enough for the block to fill and stall its input.
      set_config(THRESHOLD_RESET, 20);
      hold_requests++;
      send_windows(3, 300, 60, 30000);
      drain();

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(5))
            0: th = '0;
            1: th = TH_W'($urandom_range(50));
            2: th = THRESHOLD_RESET;
            3: th = TH_W'($urandom_range(20000));
            4: th = TH_W'($urandom);
            default: th = {TH_W{1'b1}};
         endcase
         case ($urandom_range(5))
            0: cl = 0;
            1: cl = 1;
            2, 3: cl = $urandom_range(2, 40);
            4: cl = $urandom_range(41, 254);
            default: cl = 255;
         endcase
         set_config(th, cl);
         if ($urandom_range(4) != 0) begin
            level_now = spread(LEVEL_LIMIT);
            send_windows($urandom_range(2, 8), $urandom_range(2000), $urandom_range(100),
                         $urandom_range(100000));
         end else begin
            send_noise($urandom_range(20, 80));
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("tb_window_mean_step_event_detector_top passed");
      end else begin
         $display("tb_window_mean_step_event_detector_top failed");
      end
      $finish;
   end

endmodule
